// File: hw/rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// Positional array list package
// Sizes, widths, command and status codes shared by the list core.
// ----------------------------------------------------------------------------
package pal_pkg;

  // Storage geometry
  localparam int unsigned CAPACITY    = 128;
  localparam int unsigned VALUE_WIDTH = 32;

  // Fixed port widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TOTAL_W  = 8;
  localparam int unsigned STATUS_W = 2;

  // Derived widths
  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned EXT_W  = 64;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [VALUE_WIDTH-1:0] word_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  localparam addr_t ADDR_ONE = addr_t'(1);
  localparam cnt_t  CNT_ONE  = cnt_t'(1);
  localparam cmp_t  CMP_ONE  = cmp_t'(1);
  localparam cmp_t  CMP_CAP  = cmp_t'(CAPACITY);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_READ      = 3'd2,
    CMD_OVERWRITE = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_CHECK     = 3'd5
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// File: hw/rtl/positional_array_list_core.sv
// ----------------------------------------------------------------------------
// Positional array list core
// Bounded ordered list of signed words in one simple dual-port memory,
// addressed by 1-based position, with insert, remove, read, overwrite,
// clear and ascending check.
// ----------------------------------------------------------------------------
// One command beat gives one result beat. Overwrite, clear, errors, appends,
// tail removes and checks of lists with at most one entry complete straight
// from the idle state; read waits for the registered memory read. Insert at
// p shifts the entries from p to the tail up, then writes the new word;
// remove at p shifts the later entries down; the ascending check walks all
// entries. Each moves or inspects one stored entry per cycle through the
// single read port of the list memory. A new command is taken while the
// previous result waits, as long as that result is taken in the same cycle.
// The memory needs no clearing after reset; only the entry count is reset.
module positional_array_list_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pal_pkg::CMD_W-1:0]     command_i,
  input  logic [pal_pkg::POS_W-1:0]     position_i,
  input  logic signed [pal_pkg::DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [pal_pkg::DATA_W-1:0] read_value_o,
  output logic [pal_pkg::STATUS_W-1:0]  status_o,
  output logic [pal_pkg::TOTAL_W-1:0]   entry_total_o,
  output logic                          is_empty_o,
  output logic                          ascending_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INSV,
    S_REM,
    S_RD,
    S_CHK
  } state_e;

  state_e          state_q, state_d;
  pal_pkg::cnt_t   count_q, count_d;
  pal_pkg::addr_t  ptr_q, ptr_d;
  pal_pkg::addr_t  lim_q, lim_d;
  pal_pkg::word_t  val_q, val_d;
  pal_pkg::word_t  prev_q, prev_d;
  logic            asc_q, asc_d;

  // Result register
  logic                          out_valid_q;
  logic [pal_pkg::DATA_W-1:0]    rdval_q;
  pal_pkg::status_e              status_q;
  pal_pkg::total_t               total_q;
  logic                          empty_q;
  logic                          ascout_q;

  // List memory
  pal_pkg::word_t  mem [pal_pkg::CAPACITY];
  pal_pkg::word_t  rdata_q;
  logic            mem_we, mem_re;
  pal_pkg::addr_t  mem_waddr, mem_raddr;
  pal_pkg::word_t  mem_wdata;

  // Completion of a command
  logic                 fin;
  pal_pkg::status_e     fin_status;
  pal_pkg::word_t       fin_word;
  logic                 fin_asc;
  logic                 asc_now;

  logic                        accept;
  logic [pal_pkg::EXT_W-1:0]   val_ext;
  pal_pkg::word_t              val_w;
  pal_pkg::cmp_t               pos_c, cnt_c;
  logic                        pos_zero, ins_ok, pos_ok, full;
  pal_pkg::addr_t              pos_m1, cnt_m1;
  logic [pal_pkg::EXT_W-1:0]   rd_ext;
  pal_pkg::cmp_t               tot_ext;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Fit the input word to the stored width
  assign val_ext = pal_pkg::EXT_W'(value_i);
  assign val_w   = val_ext[pal_pkg::VALUE_WIDTH-1:0];

  // Position checks on a common width
  assign pos_c    = pal_pkg::cmp_t'(position_i);
  assign cnt_c    = pal_pkg::cmp_t'(count_q);
  assign pos_zero = (pos_c == '0);
  assign ins_ok   = !pos_zero && (pos_c <= cnt_c + pal_pkg::CMP_ONE);
  assign pos_ok   = !pos_zero && (pos_c <= cnt_c);
  assign full     = (cnt_c >= pal_pkg::CMP_CAP);
  assign pos_m1   = pal_pkg::addr_t'(pos_c - pal_pkg::CMP_ONE);
  assign cnt_m1   = pal_pkg::addr_t'(cnt_c - pal_pkg::CMP_ONE);

  // Command sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    lim_d      = lim_q;
    val_d      = val_q;
    prev_d     = prev_q;
    asc_d      = asc_q;
    mem_we     = 1'b0;
    mem_waddr  = ptr_q;
    mem_wdata  = rdata_q;
    mem_re     = 1'b0;
    mem_raddr  = ptr_q;
    fin        = 1'b0;
    fin_status = pal_pkg::ST_OK;
    fin_word   = '0;
    fin_asc    = 1'b0;
    asc_now    = asc_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            pal_pkg::CMD_INSERT: begin
              if (!ins_ok) begin
                fin        = 1'b1;
                fin_status = pal_pkg::ST_RANGE;
              end else if (full) begin
                fin        = 1'b1;
                fin_status = pal_pkg::ST_FULL;
              end else if (pos_c == cnt_c + pal_pkg::CMP_ONE) begin
                // Append: nothing to shift
                mem_we    = 1'b1;
                mem_waddr = pos_m1;
                mem_wdata = val_w;
                count_d   = count_q + pal_pkg::CNT_ONE;
                fin       = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m1;
                ptr_d     = cnt_m1;
                lim_d     = pos_m1;
                val_d     = val_w;
                state_d   = S_INS;
              end
            end
            pal_pkg::CMD_REMOVE: begin
              if (!pos_ok) begin
                fin        = 1'b1;
                fin_status = pal_pkg::ST_RANGE;
              end else if (pos_c == cnt_c) begin
                // Tail entry: drop it without moving anything
                count_d = count_q - pal_pkg::CNT_ONE;
                fin     = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pal_pkg::addr_t'(pos_c);
                ptr_d     = pal_pkg::addr_t'(pos_c);
                lim_d     = cnt_m1;
                state_d   = S_REM;
              end
            end
            pal_pkg::CMD_READ: begin
              if (!pos_ok) begin
                fin        = 1'b1;
                fin_status = pal_pkg::ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_m1;
                state_d   = S_RD;
              end
            end
            pal_pkg::CMD_OVERWRITE: begin
              fin = 1'b1;
              if (!pos_ok) begin
                fin_status = pal_pkg::ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_m1;
                mem_wdata = val_w;
              end
            end
            pal_pkg::CMD_CLEAR: begin
              count_d = '0;
              fin     = 1'b1;
            end
            pal_pkg::CMD_CHECK: begin
              if (cnt_c <= pal_pkg::CMP_ONE) begin
                fin     = 1'b1;
                fin_asc = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_d     = '0;
                lim_d     = cnt_m1;
                asc_d     = 1'b1;
                state_d   = S_CHK;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Shift up: entry at ptr moves to ptr + 1, walking down to the slot
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q + pal_pkg::ADDR_ONE;
        mem_wdata = rdata_q;
        if (ptr_q == lim_q) begin
          state_d = S_INSV;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - pal_pkg::ADDR_ONE;
          ptr_d     = ptr_q - pal_pkg::ADDR_ONE;
        end
      end

      // Place the new word in the freed slot
      S_INSV: begin
        mem_we    = 1'b1;
        mem_waddr = lim_q;
        mem_wdata = val_q;
        count_d   = count_q + pal_pkg::CNT_ONE;
        fin       = 1'b1;
        state_d   = S_IDLE;
      end

      // Shift down: entry at ptr moves to ptr - 1, walking up to the tail
      S_REM: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q - pal_pkg::ADDR_ONE;
        mem_wdata = rdata_q;
        if (ptr_q == lim_q) begin
          count_d = count_q - pal_pkg::CNT_ONE;
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + pal_pkg::ADDR_ONE;
          ptr_d     = ptr_q + pal_pkg::ADDR_ONE;
        end
      end

      S_RD: begin
        fin      = 1'b1;
        fin_word = rdata_q;
        state_d  = S_IDLE;
      end

      // Compare each entry with the one before it
      S_CHK: begin
        if ((ptr_q != '0) && !($signed(prev_q) <= $signed(rdata_q))) begin
          asc_now = 1'b0;
        end
        prev_d = rdata_q;
        asc_d  = asc_now;
        if (ptr_q == lim_q) begin
          fin     = 1'b1;
          fin_asc = asc_now;
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + pal_pkg::ADDR_ONE;
          ptr_d     = ptr_q + pal_pkg::ADDR_ONE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Widen the stored word and the count for the result fields
  always_comb begin
    rd_ext = '0;
    rd_ext[pal_pkg::VALUE_WIDTH-1:0] = fin_word;
    tot_ext = '0;
    tot_ext[pal_pkg::CNT_W-1:0] = count_d;
  end

  // Hold state and the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rdval_q     <= '0;
      status_q    <= pal_pkg::ST_OK;
      total_q     <= '0;
      empty_q     <= 1'b1;
      ascout_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (fin) begin
        out_valid_q <= 1'b1;
        rdval_q     <= rd_ext[pal_pkg::DATA_W-1:0];
        status_q    <= fin_status;
        total_q     <= tot_ext[pal_pkg::TOTAL_W-1:0];
        empty_q     <= (count_d == '0);
        ascout_q    <= fin_asc;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold walk context
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    lim_q  <= lim_d;
    val_q  <= val_d;
    prev_q <= prev_d;
    asc_q  <= asc_d;
  end

  // List memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = $signed(rdval_q);
  assign status_o      = status_q;
  assign entry_total_o = total_q;
  assign is_empty_o    = empty_q;
  assign ascending_o   = ascout_q;

  // Count stays within the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_pkg::cmp_t'(count_q) <= pal_pkg::CMP_CAP)
    else $error("entry count beyond capacity");

  // A shift never reads the entry it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of one entry in one cycle");

  // A full report comes only with a full list
  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == pal_pkg::ST_FULL)) |->
      (pal_pkg::cmp_t'(entry_total_o) == pal_pkg::CMP_CAP))
    else $error("full status with room left");

  // The count moves only when a command finishes
  a_count_on_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(fin))
    else $error("entry count changed outside command completion");

endmodule
